// File: hdl/ttt_pkg.sv
// ttt_pkg: shared constants, codes and types of the tap tempo tracker.
// No dependencies; imported by every module of the block.
package ttt_pkg;

	// sample counter width
	localparam int COUNT_WIDTH = 24;

	localparam int TEMPO_W  = 32;
	localparam int LIMIT_W  = 24;
	localparam int SCALE_W  = 24;
	localparam int MS_W     = 16;
	localparam int POS_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// shared multiplier: 32 x 24 unsigned
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// wide enough for count + 1 and the limit
	localparam int CMP_W = 33;

	localparam logic [TEMPO_W-1:0] KNOB_THRESH = 32'd655360;
	localparam logic [PROD_W:0]    TAP_ROUND   = (PROD_W+1)'(128);
	localparam logic [PROD_W:0]    SM_ROUND    = (PROD_W+1)'(24'h800000);

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 24'd480000;
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd349525;
	localparam logic [MS_W-1:0]    MIN_RST   = 16'd0;
	localparam logic [MS_W-1:0]    RANGE_RST = 16'd1000;
	localparam logic [SCALE_W-1:0] COEFF_RST = 24'd1678;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_PRESS = 2'd1,
		CMD_KNOB  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT = 3'd0,
		REG_SCALE = 3'd1,
		REG_MIN   = 3'd2,
		REG_RANGE = 3'd3,
		REG_COEFF = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_TAP    = 2'd0,
		OP_KNOB   = 2'd1,
		OP_SMOOTH = 2'd2
	} op_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_PRESS,
		ST_TAP_MUL,
		ST_TAP_FIN,
		ST_KNOB_MUL,
		ST_KNOB_SUM,
		ST_KNOB_CMP,
		ST_SM_DIFF,
		ST_SM_MUL,
		ST_SM_FIN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    tick;
		logic    press;
		logic    mul_en;
		op_sel_t mul_sel;
		logic    tap_fin;
		logic    knob_sum;
		logic    knob_cmp;
		logic    sm_diff;
		logic    sm_fin;
		logic    load_out;
	} ctrl_t;

	typedef struct packed {
		logic wrapped;
		logic press_full;
		logic out_free;
	} stat_t;

endpackage

// File: hdl/ttt_mul.sv
// ttt_mul: operand select and shared 32x24 multiplier with registered product.
// Depends on ttt_pkg.
module ttt_mul (
	input  logic                                  clk,
	input  logic                                  en,
	input  ttt_pkg::op_sel_t                      sel,
	input  logic [ttt_pkg::COUNT_WIDTH-1:0]       tap_diff,
	input  logic [ttt_pkg::SCALE_W-1:0]           ms_per_sample,
	input  logic [ttt_pkg::POS_W-1:0]             knob_pos,
	input  logic [ttt_pkg::MS_W-1:0]              knob_range,
	input  logic [ttt_pkg::TEMPO_W-1:0]           sm_mag,
	input  logic [ttt_pkg::SCALE_W-1:0]           sm_coeff,
	output logic [ttt_pkg::PROD_W-1:0]            product
);
	import ttt_pkg::*;

	logic [MUL_A_W-1:0] op_a;
	logic [MUL_B_W-1:0] op_b;
	logic [PROD_W-1:0]  product_q;

	always_comb begin
		case (sel)
			OP_TAP: begin
				op_a = MUL_A_W'(tap_diff);
				op_b = MUL_B_W'(ms_per_sample);
			end
			OP_KNOB: begin
				op_a = MUL_A_W'(knob_pos);
				op_b = MUL_B_W'(knob_range);
			end
			OP_SMOOTH: begin
				op_a = sm_mag;
				op_b = MUL_B_W'(sm_coeff);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= PROD_W'(op_a) * PROD_W'(op_b);
		end
	end

	assign product = product_q;

endmodule

// File: hdl/ttt_seq.sv
// ttt_seq: sequencer that steps one word through tick, press or knob/smooth ops.
// Depends on ttt_pkg.
module ttt_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic [1:0]          command,
	input  ttt_pkg::stat_t      stat,
	output logic                item_stall,
	output ttt_pkg::ctrl_t      ctrl
);
	import ttt_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		ctrl = '0;
		ctrl.mul_sel = OP_TAP;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					ctrl.accept = 1'b1;
					case (command)
						CMD_TICK:  state_next = ST_TICK;
						CMD_PRESS: state_next = ST_PRESS;
						CMD_KNOB:  state_next = ST_KNOB_MUL;
						default:   state_next = ST_WRITE;
					endcase
				end
			end
			ST_TICK: begin
				ctrl.tick = 1'b1;
				state_next = ST_WRITE;
			end
			ST_PRESS: begin
				ctrl.press = 1'b1;
				if (!stat.wrapped && stat.press_full) begin
					state_next = ST_TAP_MUL;
				end else begin
					state_next = ST_WRITE;
				end
			end
			ST_TAP_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = OP_TAP;
				state_next = ST_TAP_FIN;
			end
			ST_TAP_FIN: begin
				ctrl.tap_fin = 1'b1;
				state_next = ST_WRITE;
			end
			ST_KNOB_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = OP_KNOB;
				state_next = ST_KNOB_SUM;
			end
			ST_KNOB_SUM: begin
				ctrl.knob_sum = 1'b1;
				state_next = ST_KNOB_CMP;
			end
			ST_KNOB_CMP: begin
				ctrl.knob_cmp = 1'b1;
				state_next = ST_SM_DIFF;
			end
			ST_SM_DIFF: begin
				ctrl.sm_diff = 1'b1;
				state_next = ST_SM_MUL;
			end
			ST_SM_MUL: begin
				ctrl.mul_en = 1'b1;
				ctrl.mul_sel = OP_SMOOTH;
				state_next = ST_SM_FIN;
			end
			ST_SM_FIN: begin
				ctrl.sm_fin = 1'b1;
				state_next = ST_WRITE;
			end
			ST_WRITE: begin
				if (stat.out_free) begin
					ctrl.load_out = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/tap_tempo_tracker_core.sv
// tap_tempo_tracker_core: top level; config registers, tracker state, output register.
// Depends on ttt_pkg, ttt_mul, ttt_seq.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------
//  item    | item_valid/item_stall  | command, knob_position
//  result  | result_valid/result_stall | tempo_ms, tap_mode
//  cfg     | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// States per word: unused command: write; tick: tick, write; press: press, tap
// multiply and tap finish (when it sets the tap period), write; knob update: knob
// multiply, knob sum, knob compare, smooth diff, smooth multiply, smooth finish,
// write. Products use the one shared 32x24 multiplier. Result register holds a
// word while result_stall; the next word can be taken meanwhile, and waits in the
// write state until it frees. Reset skips working and payload regs; cfg_ready is always high.
module tap_tempo_tracker_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         command,
	input  logic [ttt_pkg::POS_W-1:0]          knob_position,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [ttt_pkg::TEMPO_W-1:0]        tempo_ms,
	output logic                               tap_mode,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ttt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ttt_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// config registers
	logic [LIMIT_W-1:0] counter_limit_q;
	logic [SCALE_W-1:0] ms_per_sample_q;
	logic [MS_W-1:0]    delay_min_q;
	logic [MS_W-1:0]    delay_range_q;
	logic [SCALE_W-1:0] smooth_coeff_q;

	// tracker state
	logic [COUNT_WIDTH-1:0] sample_count_q;
	logic                   wrapped_q;
	logic [COUNT_WIDTH-1:0] hist_q [3];
	logic [1:0]             press_count_q;
	logic                   tap_active_q;
	logic [TEMPO_W-1:0]     tap_period_q;
	logic [TEMPO_W-1:0]     knob_period_q;
	logic [TEMPO_W-1:0]     smoothed_q;

	// working registers
	logic [POS_W-1:0]   pos_q;
	logic [TEMPO_W-1:0] kt_q;
	logic [TEMPO_W-1:0] mag_q;
	logic               up_q;

	// output register
	logic               result_valid_q;
	logic [TEMPO_W-1:0] tempo_q;
	logic               tap_mode_q;

	logic [PROD_W-1:0]      product;
	logic [COUNT_WIDTH-1:0] tap_diff;
	logic [COUNT_WIDTH:0]   count_next;
	logic                   count_wrap;
	logic [PROD_W:0]        tap_sum;
	logic [PROD_W-8:0]      tap_val;
	logic [TEMPO_W:0]       knob_sum;
	logic [TEMPO_W-1:0]     knob_gap;
	logic [TEMPO_W-1:0]     sm_target;
	logic [PROD_W:0]        sm_sum;
	logic [TEMPO_W-1:0]     sm_step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_limit_q <= LIMIT_RST;
			ms_per_sample_q <= SCALE_RST;
			delay_min_q     <= MIN_RST;
			delay_range_q   <= RANGE_RST;
			smooth_coeff_q  <= COEFF_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIMIT: counter_limit_q <= LIMIT_W'(cfg_data);
				REG_SCALE: ms_per_sample_q <= SCALE_W'(cfg_data);
				REG_MIN:   delay_min_q     <= MS_W'(cfg_data);
				REG_RANGE: delay_range_q   <= MS_W'(cfg_data);
				REG_COEFF: smooth_coeff_q  <= SCALE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	ttt_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.command    (command),
		.stat       (stat),
		.item_stall (item_stall),
		.ctrl       (ctrl)
	);

	assign tap_diff = hist_q[0] - hist_q[1];

	ttt_mul u_mul (
		.clk           (clk),
		.en            (ctrl.mul_en),
		.sel           (ctrl.mul_sel),
		.tap_diff      (tap_diff),
		.ms_per_sample (ms_per_sample_q),
		.knob_pos      (pos_q),
		.knob_range    (delay_range_q),
		.sm_mag        (mag_q),
		.sm_coeff      (smooth_coeff_q),
		.product       (product)
	);

	assign stat.wrapped    = wrapped_q;
	assign stat.press_full = (press_count_q == 2'd3);
	assign stat.out_free   = !result_valid_q || !result_stall;

	// wrap at the limit, or when the count would leave its width
	assign count_next = {1'b0, sample_count_q} + (COUNT_WIDTH+1)'(1);
	assign count_wrap = count_next[COUNT_WIDTH] ||
		(CMP_W'(count_next) >= CMP_W'(counter_limit_q));

	assign tap_sum = {1'b0, product} + TAP_ROUND;
	assign tap_val = tap_sum[PROD_W:8];

	assign knob_sum = {1'b0, delay_min_q, 16'h0000} + {1'b0, product[TEMPO_W-1:0]};
	assign knob_gap = (kt_q > knob_period_q) ? (kt_q - knob_period_q)
		: (knob_period_q - kt_q);

	assign sm_target = tap_active_q ? tap_period_q : knob_period_q;
	assign sm_sum  = {1'b0, product} + SM_ROUND;
	// step never exceeds the magnitude, so 32 bits hold it
	assign sm_step = sm_sum[TEMPO_W+23:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			wrapped_q      <= 1'b0;
			hist_q[0]      <= '0;
			hist_q[1]      <= '0;
			hist_q[2]      <= '0;
			press_count_q  <= 2'd1;
			tap_active_q   <= 1'b0;
			tap_period_q   <= '0;
			knob_period_q  <= '0;
			smoothed_q     <= '0;
		end else begin
			if (ctrl.tick) begin
				if (count_wrap) begin
					sample_count_q <= '0;
					wrapped_q      <= 1'b1;
				end else begin
					sample_count_q <= count_next[COUNT_WIDTH-1:0];
				end
			end
			if (ctrl.press) begin
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= sample_count_q;
				if (wrapped_q) begin
					sample_count_q <= '0;
					wrapped_q      <= 1'b0;
					press_count_q  <= 2'd1;
				end else if (!stat.press_full) begin
					press_count_q <= press_count_q + 2'd1;
				end
			end
			if (ctrl.tap_fin) begin
				tap_active_q <= 1'b1;
				tap_period_q <= (|tap_val[PROD_W-8:TEMPO_W]) ? '1 : tap_val[TEMPO_W-1:0];
			end
			if (ctrl.knob_cmp && (knob_gap > KNOB_THRESH)) begin
				knob_period_q <= kt_q;
				tap_active_q  <= 1'b0;
			end
			if (ctrl.sm_fin) begin
				smoothed_q <= up_q ? (smoothed_q + sm_step) : (smoothed_q - sm_step);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			pos_q <= knob_position;
		end
		if (ctrl.knob_sum) begin
			kt_q <= knob_sum[TEMPO_W] ? '1 : knob_sum[TEMPO_W-1:0];
		end
		if (ctrl.sm_diff) begin
			up_q  <= (sm_target >= smoothed_q);
			mag_q <= (sm_target >= smoothed_q) ? (sm_target - smoothed_q)
				: (smoothed_q - sm_target);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			tempo_q    <= smoothed_q;
			tap_mode_q <= tap_active_q;
		end
	end

	assign result_valid = result_valid_q;
	assign tempo_ms     = tempo_q;
	assign tap_mode     = tap_mode_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item taken while a word is in work");

	a_press_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		press_count_q != 2'd0)
		else $error("press count reached zero");

	a_tap_on_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tap_active_q) |-> $past(ctrl.tap_fin))
		else $error("tap mode set outside a tap period update");

	a_no_overshoot_up: assert property (@(posedge clk) disable iff (!arst_n)
		($past(ctrl.sm_fin) && $past(up_q)) |-> (smoothed_q <= $past(sm_target, 3)))
		else $error("smoother overshot target going up");

	a_no_overshoot_down: assert property (@(posedge clk) disable iff (!arst_n)
		($past(ctrl.sm_fin) && !$past(up_q)) |-> (smoothed_q >= $past(sm_target, 3)))
		else $error("smoother overshot target going down");
`endif

endmodule

// File: tb/tb_tap_tempo_tracker_core.sv
`timescale 1ns / 100ps
// tb_tap_tempo_tracker_core: self-checking bench for the tap tempo tracker core.
// Random bursty words against an in-bench tracker model; needs ttt_pkg and the core.
module tb_tap_tempo_tracker_core;
	import ttt_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_AT_WORD = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_BACKLOG = 8;
	localparam int SETTLE       = 12;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_B = 3'd7;
	localparam longint unsigned Q16_TOP = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [POS_W-1:0] pos;
	} tap_word_t;

	typedef struct packed {
		logic [TEMPO_W-1:0] tempo;
		logic               tap;
	} tempo_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] command = 2'd0;
	logic [POS_W-1:0] knob_position = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [TEMPO_W-1:0] tempo_ms;
	logic tap_mode;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tap_tempo_tracker_core uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .knob_position(knob_position),
		.result_valid(result_valid), .result_stall(result_stall),
		.tempo_ms(tempo_ms), .tap_mode(tap_mode),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// tracker model state and its copy of the registers
	logic [LIMIT_W-1:0] m_limit = LIMIT_RST;
	logic [SCALE_W-1:0] m_scale = SCALE_RST;
	logic [MS_W-1:0]    m_min   = MIN_RST;
	logic [MS_W-1:0]    m_range = RANGE_RST;
	logic [SCALE_W-1:0] m_coeff = COEFF_RST;
	logic [COUNT_WIDTH-1:0] m_count = '0;
	logic m_wrapped = 1'b0;
	logic [COUNT_WIDTH-1:0] m_hist [3] = '{default: '0};
	int unsigned m_presses = 1;
	logic m_tap_on = 1'b0;
	logic [TEMPO_W-1:0] m_tap_per = '0;
	logic [TEMPO_W-1:0] m_knob_per = '0;
	logic [TEMPO_W-1:0] m_smooth = '0;

	tap_word_t   pending_words [$];
	tempo_word_t tempo_q [$];
	tap_word_t   cur_word;
	tempo_word_t want_w;
	int n_pushed = 0, n_accepted = 0, n_results = 0, n_errors = 0;
	int n_ticks = 0, n_presses = 0, n_knobs = 0, n_unused = 0;
	int n_wraps = 0, n_tap_sets = 0, n_cfg = 0;
	int cycle_cnt = 0;
	int burst_left = 1, gap_left = 0;
	int hold_left = 0, stall_mode = 0, stall_left = 0;
	bit hold_done = 1'b0;
	logic [POS_W-1:0] last_knob = '0;

	function automatic logic [TEMPO_W-1:0] sat_q16(input longint unsigned v);
		return (v > Q16_TOP) ? '1 : TEMPO_W'(v);
	endfunction

	function automatic tempo_word_t track_word(input tap_word_t w);
		longint unsigned nxt, cmask, diff, kt, mag, step;
		logic [TEMPO_W-1:0] kq, gap, target;
		tempo_word_t r;
		cmask = (64'd1 << COUNT_WIDTH) - 1;
		case (w.cmd)
		CMD_TICK: begin
			n_ticks++;
			nxt = longint'(m_count) + 1;
			if (nxt >= longint'(m_limit) || nxt > cmask) begin
				m_count = '0;
				m_wrapped = 1'b1;
				n_wraps++;
			end else begin
				m_count = COUNT_WIDTH'(nxt);
			end
		end
		CMD_PRESS: begin
			n_presses++;
			m_hist[2] = m_hist[1];
			m_hist[1] = m_hist[0];
			m_hist[0] = m_count;
			if (m_wrapped) begin
				m_count = '0;
				m_wrapped = 1'b0;
				m_presses = 1;
			end else if (m_presses < 3) begin
				m_presses++;
			end else begin
				diff = (longint'(m_hist[0]) - longint'(m_hist[1])) & cmask;
				m_tap_per = sat_q16((diff * longint'(m_scale) + 128) >> 8);
				m_tap_on = 1'b1;
				n_tap_sets++;
			end
		end
		CMD_KNOB: begin
			n_knobs++;
			kt = (longint'(m_min) << 16) + longint'(w.pos) * longint'(m_range);
			kq = sat_q16(kt);
			gap = (kq > m_knob_per) ? kq - m_knob_per : m_knob_per - kq;
			if (gap > KNOB_THRESH) begin
				m_knob_per = kq;
				m_tap_on = 1'b0;
			end
			target = m_tap_on ? m_tap_per : m_knob_per;
			if (target >= m_smooth) begin
				mag = longint'(target - m_smooth);
				step = (mag * longint'(m_coeff) + 64'h80_0000) >> 24;
				m_smooth = m_smooth + TEMPO_W'(step);
			end else begin
				mag = longint'(m_smooth - target);
				step = (mag * longint'(m_coeff) + 64'h80_0000) >> 24;
				m_smooth = m_smooth - TEMPO_W'(step);
			end
		end
		default: n_unused++;
		endcase
		r.tempo = m_smooth;
		r.tap = m_tap_on;
		return r;
	endfunction

	// word driver: bursts of random length, random gaps between them
	always @(posedge clk) begin
		cycle_cnt++;
		if (item_valid && !item_stall) begin
			tempo_q.push_back(track_word(cur_word));
			n_accepted++;
		end
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || !item_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				cur_word = pending_words.pop_front();
				command <= cur_word.cmd;
				knob_position <= cur_word.pos;
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
				end else begin
					burst_left--;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result stall pattern, with one long hold-off so the core backs up
	always @(posedge clk) begin
		if (!hold_done && n_accepted >= HOLD_AT_WORD &&
				pending_words.size() >= HOLD_BACKLOG) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(20, 80);
		end else begin
			stall_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= 1'($urandom_range(0, 1));
			default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			n_results++;
			if (tempo_q.size() == 0) begin
				$error("result word with nothing expected: tempo_ms %h tap_mode %b",
					tempo_ms, tap_mode);
				n_errors++;
			end else begin
				want_w = tempo_q.pop_front();
				if (tempo_ms !== want_w.tempo) begin
					$error("tempo_ms: expected %h, got %h", want_w.tempo, tempo_ms);
					n_errors++;
				end
				if (tap_mode !== want_w.tap) begin
					$error("tap_mode: expected %b, got %b", want_w.tap, tap_mode);
					n_errors++;
				end
			end
		end
	end

	task automatic push_word(input logic [1:0] cmd, input logic [POS_W-1:0] pos);
		tap_word_t w;
		w.cmd = cmd;
		w.pos = pos;
		pending_words.push_back(w);
		n_pushed++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
		REG_LIMIT: m_limit = val[LIMIT_W-1:0];
		REG_SCALE: m_scale = val[SCALE_W-1:0];
		REG_MIN:   m_min = val[MS_W-1:0];
		REG_RANGE: m_range = val[MS_W-1:0];
		REG_COEFF: m_coeff = val[SCALE_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_regs(input logic [LIMIT_W-1:0] lim, input logic [SCALE_W-1:0] scl,
			input logic [MS_W-1:0] mn, input logic [MS_W-1:0] rng,
			input logic [SCALE_W-1:0] cf);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_SCALE, scl);
		write_reg(REG_MIN, CFG_DATA_W'(mn));
		write_reg(REG_RANGE, CFG_DATA_W'(rng));
		write_reg(REG_COEFF, cf);
	endtask

	// wait until every word has come back and the core has gone quiet
	task automatic drain();
		wait (n_results == n_pushed);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] pick_knob();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		2: return last_knob;
		3: return last_knob + POS_W'($urandom_range(0, 15));
		4: return last_knob - POS_W'($urandom_range(0, 15));
		default: return POS_W'($urandom);
		endcase
	endfunction

	// mostly tap sequences (ticks then a press, repeated), some knob moves and noise
	task automatic add_random(input int n, input int max_ticks);
		int start, k, t;
		logic [POS_W-1:0] p;
		start = n_pushed;
		while (n_pushed - start < n) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				k = $urandom_range(2, 5);
				repeat (k) begin
					t = $urandom_range(0, max_ticks);
					repeat (t) push_word(CMD_TICK, POS_W'($urandom));
					push_word(CMD_PRESS, POS_W'($urandom));
					if ($urandom_range(0, 2) == 0)
						push_word(CMD_KNOB, last_knob);
				end
			end
			6, 7: begin
				k = $urandom_range(1, 6);
				repeat (k) begin
					p = pick_knob();
					last_knob = p;
					push_word(CMD_KNOB, p);
				end
			end
			default: begin
				k = $urandom_range(1, 5);
				repeat (k) push_word(2'($urandom_range(0, 3)), POS_W'($urandom));
			end
			endcase
		end
	endtask

	initial begin : timeout
		wait (cycle_cnt >= LIMIT_CYCLES);
		$display("tap_tempo_tracker_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass on reset register values
		push_word(CMD_UNUSED, '1);
		push_word(CMD_KNOB, '0);
		push_word(CMD_KNOB, '1);
		push_word(CMD_KNOB, '1);
		push_word(CMD_KNOB, 16'h000A);
		push_word(CMD_KNOB, 16'h000B);     // within 10 ms: knob tempo kept
		push_word(CMD_PRESS, '0);
		repeat (3) push_word(CMD_TICK, 16'h5555);
		push_word(CMD_PRESS, 16'hAAAA);
		repeat (5) push_word(CMD_TICK, 16'hAAAA);
		push_word(CMD_PRESS, '0);          // third press sets the tap tempo
		push_word(CMD_PRESS, '1);          // zero gap between presses
		push_word(CMD_KNOB, 16'h000B);     // tap target, smoothing step
		push_word(CMD_UNUSED, '0);
		push_word(CMD_KNOB, 16'h8000);     // big knob move drops tap mode
		last_knob = 16'h8000;
		drain();

		// short wrap period, quarter coefficient
		set_regs(24'd20, SCALE_RST, 16'd0, 16'd1000, 24'h40_0000);
		add_random(200, 25);
		drain();

		// every tick wraps; knob tempos saturate; full coefficient
		set_regs(24'd1, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);
		add_random(120, 3);
		drain();

		// all registers at zero
		set_regs(24'd0, 24'd0, 16'd0, 16'd0, 24'd0);
		add_random(100, 3);
		drain();

		// top limit and scale, plus writes to unused register slots
		set_regs(24'hFF_FFFF, 24'hFF_FFFF, 16'd300, 16'd2000, 24'h10_0000);
		write_reg(REG_NONE_A, 24'h00_0001);
		write_reg(REG_NONE_B, 24'hFF_FFFF);
		add_random(200, 30);
		drain();

		set_regs(24'($urandom_range(2, 200)), 24'($urandom), 16'($urandom),
			16'($urandom), 24'($urandom));
		add_random(250, 60);
		drain();

		set_regs(LIMIT_RST, SCALE_RST, 16'd50, 16'd3000, 24'($urandom_range(1, 24'h20_0000)));
		add_random(230, 40);
		drain();

		$display("covered %0d words: %0d ticks, %0d presses, %0d knob, %0d unused",
			n_accepted, n_ticks, n_presses, n_knobs, n_unused);
		$display("  %0d counter wraps, %0d tap tempos set, %0d register writes",
			n_wraps, n_tap_sets, n_cfg);
		if (n_errors == 0 && tempo_q.size() == 0)
			$display("tap_tempo_tracker_core: match");
		else
			$display("tap_tempo_tracker_core: mismatch");
		$finish;
	end

endmodule
